// ----- hw/rtl/qte_pkg.sv -----
// Shared types and constants of the quaternion to XYZ Euler angle converter.
// Used by every module in hw/rtl; depends on nothing.
`timescale 1ns / 1ps
package qte_pkg;

   localparam int CW           = 16;              // input component width
   localparam int BLOCK_MSB    = 13;              // normalised magnitude in [2^13, 2^14)
   localparam int NW           = BLOCK_MSB + 2;   // normalised signed width
   localparam int SW           = CW + BLOCK_MSB + 1;
   localparam int PW           = 2 * NW + 2;      // product width
   localparam int OPW          = PW + 2;          // matrix term width
   localparam int LW           = 54;              // gimbal compare width
   localparam int LIMIT_SHIFT  = 22;
   localparam int GL_W         = 23;
   localparam int AZ_W         = 16;
   localparam int SQRT_STEPS   = 31;
   localparam int RW           = 2 * SQRT_STEPS;
   localparam int STEP_W       = 5;
   localparam int CORDIC_STEPS = 24;
   localparam int PRESCALE     = 24;
   localparam int VW           = 60;
   localparam int ZW           = 34;
   localparam int AF           = 21;              // angle fraction bits
   localparam int ROLL_W       = 24;
   localparam int PITCH_W      = 23;
   localparam int YAW_W        = 24;
   localparam int LANE_ROLL    = 0;
   localparam int LANE_PITCH   = 1;
   localparam int LANE_YAW     = 2;

   localparam logic [GL_W-1:0] GIMBAL_RESET = 23'd4194262;
   localparam logic [AZ_W-1:0] ZERO_RESET   = 16'd21;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   localparam logic [0:0] REG_GIMBAL = 1'b0;
   localparam logic [0:0] REG_ZERO   = 1'b1;

   typedef struct packed {
      logic signed [OPW-1:0] s;
      logic signed [OPW-1:0] roll_y;
      logic signed [OPW-1:0] roll_x;
      logic signed [OPW-1:0] yaw_y;
      logic signed [OPW-1:0] yaw_x;
      logic                  locked;
      logic                  zeroq;
   } qte_side_type;

   typedef struct packed {
      logic                  valid;
      logic [RW-1:0]         rem;
      logic [SQRT_STEPS-1:0] root;
      qte_side_type          side;
   } qte_root_type;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } qte_vec_type;

   typedef struct packed {
      logic              valid;
      logic              locked;
      logic              zeroq;
      logic              spos;
      qte_vec_type [2:0] lane;
   } qte_cord_type;

endpackage

// ----- hw/rtl/quaternion_to_euler_xyz.sv -----
// Quaternion to XYZ Euler angles: pipelined from input transfer to result.
// Throughput one item per cycle; the whole chain holds while a result is stalled.
// Front end of seven stages, 31 square root cells, one quadrant stage,
// 24 CORDIC cells and the result register set the latency.
// Synchronous reset empties the pipeline and restores both registers.
`timescale 1ns / 1ps
module quaternion_to_euler_xyz (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [qte_pkg::CW-1:0]      req_quat_w,
   input  logic signed [qte_pkg::CW-1:0]      req_quat_x,
   input  logic signed [qte_pkg::CW-1:0]      req_quat_y,
   input  logic signed [qte_pkg::CW-1:0]      req_quat_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qte_pkg::ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [qte_pkg::YAW_W-1:0]   rsp_yaw_angle,
   output logic                               rsp_gimbal_locked,
   output logic                               rsp_zero_quaternion,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic                        advance;
   logic [qte_pkg::GL_W-1:0]    gimbal_limit_ff;
   logic [qte_pkg::AZ_W-1:0]    zero_limit_ff;
   logic signed [qte_pkg::CW-1:0] quat [4];

   qte_pkg::qte_root_type root_chain [qte_pkg::SQRT_STEPS+1];
   qte_pkg::qte_cord_type cord_chain [qte_pkg::CORDIC_STEPS+1];
   qte_pkg::qte_cord_type entry_in;
   logic                  entry_valid_ff;
   qte_pkg::qte_cord_type entry_ff;

   logic                               rsp_valid_ff;
   logic signed [qte_pkg::ROLL_W-1:0]  roll_in, roll_ff;
   logic signed [qte_pkg::PITCH_W-1:0] pitch_in, pitch_ff;
   logic signed [qte_pkg::YAW_W-1:0]   yaw_in, yaw_ff;
   logic                               locked_in, locked_ff, zeroq_in, zeroq_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == qte_pkg::REG_GIMBAL) ? 32'(gimbal_limit_ff)
                                                        : 32'(zero_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gimbal_limit_ff <= qte_pkg::GIMBAL_RESET;
         zero_limit_ff   <= qte_pkg::ZERO_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[2])
            qte_pkg::REG_GIMBAL: gimbal_limit_ff <= pwdata[qte_pkg::GL_W-1:0];
            qte_pkg::REG_ZERO:   zero_limit_ff   <= pwdata[qte_pkg::AZ_W-1:0];
            default: ;
         endcase
      end
   end

   assign quat[0] = req_quat_w;
   assign quat[1] = req_quat_x;
   assign quat[2] = req_quat_y;
   assign quat[3] = req_quat_z;

   qte_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (req_valid),
      .quat         (quat),
      .gimbal_limit (gimbal_limit_ff),
      .out          (root_chain[0])
   );

   for (genvar k = 0; k < qte_pkg::SQRT_STEPS; k++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (advance),
         .step     (qte_pkg::STEP_W'(qte_pkg::SQRT_STEPS - 1 - k)),
         .in_data  (root_chain[k]),
         .out_data (root_chain[k+1])
      );
   end

   always_comb begin
      logic signed [qte_pkg::OPW-1:0] oy [3];
      logic signed [qte_pkg::OPW-1:0] ox [3];
      logic signed [qte_pkg::VW-1:0]  xv, yv;
      qte_pkg::qte_side_type sd;
      sd = root_chain[qte_pkg::SQRT_STEPS].side;
      oy[qte_pkg::LANE_ROLL]  = sd.roll_y;
      ox[qte_pkg::LANE_ROLL]  = sd.roll_x;
      oy[qte_pkg::LANE_PITCH] = sd.s;
      ox[qte_pkg::LANE_PITCH] = qte_pkg::OPW'(root_chain[qte_pkg::SQRT_STEPS].root);
      oy[qte_pkg::LANE_YAW]   = sd.yaw_y;
      ox[qte_pkg::LANE_YAW]   = sd.yaw_x;
      entry_in.valid  = root_chain[qte_pkg::SQRT_STEPS].valid;
      entry_in.locked = sd.locked;
      entry_in.zeroq  = sd.zeroq;
      entry_in.spos   = (sd.s >= 0);
      for (int l = 0; l < 3; l++) begin
         xv = qte_pkg::VW'(ox[l]) <<< qte_pkg::PRESCALE;
         yv = qte_pkg::VW'(oy[l]) <<< qte_pkg::PRESCALE;
         entry_in.lane[l].zero = (ox[l] == 0) && (oy[l] == 0);
         if (xv < 0) begin
            if (yv >= 0) begin
               entry_in.lane[l].x = yv;
               entry_in.lane[l].y = -xv;
               entry_in.lane[l].z = qte_pkg::HALF_PI_Q30;
            end else begin
               entry_in.lane[l].x = -yv;
               entry_in.lane[l].y = xv;
               entry_in.lane[l].z = -qte_pkg::HALF_PI_Q30;
            end
         end else begin
            entry_in.lane[l].x = xv;
            entry_in.lane[l].y = yv;
            entry_in.lane[l].z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   always_comb begin
      cord_chain[0]       = entry_ff;
      cord_chain[0].valid = entry_valid_ff;
   end

   for (genvar i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin : g_cordic
      qte_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .step      (qte_pkg::STEP_W'(i)),
         .atan_step (qte_pkg::ATAN_Q30[i]),
         .in_data   (cord_chain[i]),
         .out_data  (cord_chain[i+1])
      );
   end

   always_comb begin
      logic signed [qte_pkg::ZW-1:0] zs [3];
      logic signed [qte_pkg::ZW-1:0] r  [3];
      logic signed [qte_pkg::ZW-1:0] m;
      qte_pkg::qte_cord_type cd;
      cd = cord_chain[qte_pkg::CORDIC_STEPS];
      for (int l = 0; l < 3; l++) begin
         zs[l] = cd.lane[l].zero ? '0 : cd.lane[l].z;
      end
      if (cd.locked) begin
         zs[qte_pkg::LANE_PITCH] = cd.spos ? qte_pkg::HALF_PI_Q30 : -qte_pkg::HALF_PI_Q30;
         zs[qte_pkg::LANE_YAW]   = '0;
      end
      for (int l = 0; l < 3; l++) begin
         r[l] = (zs[l] + (qte_pkg::ZW'(1) <<< (29 - qte_pkg::AF))) >>> (30 - qte_pkg::AF);
         m    = (r[l] < 0) ? -r[l] : r[l];
         if (cd.zeroq || (m < $signed(qte_pkg::ZW'(zero_limit_ff)))) begin
            r[l] = '0;
         end
      end
      roll_in   = r[qte_pkg::LANE_ROLL][qte_pkg::ROLL_W-1:0];
      pitch_in  = r[qte_pkg::LANE_PITCH][qte_pkg::PITCH_W-1:0];
      yaw_in    = r[qte_pkg::LANE_YAW][qte_pkg::YAW_W-1:0];
      locked_in = cd.locked && !cd.zeroq;
      zeroq_in  = cd.zeroq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cord_chain[qte_pkg::CORDIC_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         roll_ff   <= roll_in;
         pitch_ff  <= pitch_in;
         yaw_ff    <= yaw_in;
         locked_ff <= locked_in;
         zeroq_ff  <= zeroq_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_yaw_angle       = yaw_ff;
   assign rsp_gimbal_locked   = locked_ff;
   assign rsp_zero_quaternion = zeroq_ff;

endmodule

// ----- hw/rtl/qte_front.sv -----
// Front end: block normalisation, rotation matrix terms and gimbal test.
// Seven register stages; depends on qte_pkg.
`timescale 1ns / 1ps
module qte_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [qte_pkg::CW-1:0] quat [4],
   input  logic [qte_pkg::GL_W-1:0]      gimbal_limit,
   output qte_pkg::qte_root_type         out
);

   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff;

   logic [qte_pkg::CW-1:0] a_mag_ff [4];
   logic                   a_neg_ff [4];

   logic signed [qte_pkg::NW-1:0] b_q_in [4];
   logic signed [qte_pkg::NW-1:0] b_q_ff [4];
   logic                          b_zero_in, b_zero_ff;

   logic signed [qte_pkg::NW-1:0] c_q_ff [4];
   logic signed [qte_pkg::NW:0]   c_d_ff [4];
   logic                          c_zero_ff;

   logic signed [qte_pkg::PW-1:0] d_p_ff [14];
   logic                          d_zero_ff;

   logic signed [qte_pkg::OPW-1:0] e_n_ff, e_s_ff, e_ry_ff, e_rx_ff, e_yy_ff, e_yx_ff;
   logic signed [qte_pkg::OPW-1:0] e_ay_ff, e_ax_ff, e_lo_ff, e_hi_ff;
   logic                           e_zero_ff;

   logic [qte_pkg::LW-1:0]         f_as_ff, f_ln_ff;
   logic [qte_pkg::RW-1:0]         f_lohi_ff;
   logic signed [qte_pkg::OPW-1:0] f_s_ff, f_ry_ff, f_rx_ff, f_yy_ff, f_yx_ff;
   logic signed [qte_pkg::OPW-1:0] f_ay_ff, f_ax_ff;
   logic                           f_zero_ff;
   logic signed [qte_pkg::OPW-1:0] s_abs;

   qte_pkg::qte_root_type g_in, g_ff;

   always_comb begin
      logic [qte_pkg::CW-1:0] big;
      logic [qte_pkg::STEP_W-1:0] p;
      logic [qte_pkg::SW-1:0] t;
      big = '0;
      p   = '0;
      for (int k = 0; k < 4; k++) begin
         if (a_mag_ff[k] > big) begin
            big = a_mag_ff[k];
         end
      end
      for (int b = 0; b < qte_pkg::CW; b++) begin
         if (big[b]) begin
            p = qte_pkg::STEP_W'(b);
         end
      end
      b_zero_in = (big == '0);
      for (int k = 0; k < 4; k++) begin
         t = qte_pkg::SW'(a_mag_ff[k]);
         if (p > qte_pkg::STEP_W'(qte_pkg::BLOCK_MSB)) begin
            t = t >> (p - qte_pkg::STEP_W'(qte_pkg::BLOCK_MSB));
         end else begin
            t = t << (qte_pkg::STEP_W'(qte_pkg::BLOCK_MSB) - p);
         end
         b_q_in[k] = a_neg_ff[k] ? -$signed(qte_pkg::NW'(t)) : $signed(qte_pkg::NW'(t));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   assign s_abs = (e_s_ff < 0) ? -e_s_ff : e_s_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            a_neg_ff[k] <= quat[k][qte_pkg::CW-1];
            a_mag_ff[k] <= quat[k][qte_pkg::CW-1] ? qte_pkg::CW'(-quat[k])
                                                  : qte_pkg::CW'(quat[k]);
            b_q_ff[k]   <= b_q_in[k];
            c_q_ff[k]   <= b_q_ff[k];
         end
         b_zero_ff <= b_zero_in;
         c_zero_ff <= b_zero_ff;
         c_d_ff[0] <= (qte_pkg::NW+1)'(b_q_ff[0]) - (qte_pkg::NW+1)'(b_q_ff[2]);
         c_d_ff[1] <= (qte_pkg::NW+1)'(b_q_ff[1]) + (qte_pkg::NW+1)'(b_q_ff[3]);
         c_d_ff[2] <= (qte_pkg::NW+1)'(b_q_ff[0]) + (qte_pkg::NW+1)'(b_q_ff[2]);
         c_d_ff[3] <= (qte_pkg::NW+1)'(b_q_ff[1]) - (qte_pkg::NW+1)'(b_q_ff[3]);

         d_zero_ff <= c_zero_ff;
         d_p_ff[0]  <= qte_pkg::PW'(c_q_ff[0]) * qte_pkg::PW'(c_q_ff[0]);
         d_p_ff[1]  <= qte_pkg::PW'(c_q_ff[1]) * qte_pkg::PW'(c_q_ff[1]);
         d_p_ff[2]  <= qte_pkg::PW'(c_q_ff[2]) * qte_pkg::PW'(c_q_ff[2]);
         d_p_ff[3]  <= qte_pkg::PW'(c_q_ff[3]) * qte_pkg::PW'(c_q_ff[3]);
         d_p_ff[4]  <= qte_pkg::PW'(c_q_ff[0]) * qte_pkg::PW'(c_q_ff[2]);
         d_p_ff[5]  <= qte_pkg::PW'(c_q_ff[1]) * qte_pkg::PW'(c_q_ff[3]);
         d_p_ff[6]  <= qte_pkg::PW'(c_q_ff[2]) * qte_pkg::PW'(c_q_ff[3]);
         d_p_ff[7]  <= qte_pkg::PW'(c_q_ff[0]) * qte_pkg::PW'(c_q_ff[1]);
         d_p_ff[8]  <= qte_pkg::PW'(c_q_ff[1]) * qte_pkg::PW'(c_q_ff[2]);
         d_p_ff[9]  <= qte_pkg::PW'(c_q_ff[0]) * qte_pkg::PW'(c_q_ff[3]);
         for (int k = 0; k < 4; k++) begin
            d_p_ff[10+k] <= qte_pkg::PW'(c_d_ff[k]) * qte_pkg::PW'(c_d_ff[k]);
         end

         e_zero_ff <= d_zero_ff;
         e_n_ff  <= qte_pkg::OPW'(d_p_ff[0]) + qte_pkg::OPW'(d_p_ff[1])
                  + qte_pkg::OPW'(d_p_ff[2]) + qte_pkg::OPW'(d_p_ff[3]);
         e_s_ff  <= (qte_pkg::OPW'(d_p_ff[4]) - qte_pkg::OPW'(d_p_ff[5])) <<< 1;
         e_ry_ff <= (qte_pkg::OPW'(d_p_ff[6]) + qte_pkg::OPW'(d_p_ff[7])) <<< 1;
         e_rx_ff <= qte_pkg::OPW'(d_p_ff[0]) + qte_pkg::OPW'(d_p_ff[3])
                  - qte_pkg::OPW'(d_p_ff[1]) - qte_pkg::OPW'(d_p_ff[2]);
         e_yy_ff <= (qte_pkg::OPW'(d_p_ff[8]) + qte_pkg::OPW'(d_p_ff[9])) <<< 1;
         e_yx_ff <= qte_pkg::OPW'(d_p_ff[0]) + qte_pkg::OPW'(d_p_ff[1])
                  - qte_pkg::OPW'(d_p_ff[2]) - qte_pkg::OPW'(d_p_ff[3]);
         e_ay_ff <= (qte_pkg::OPW'(d_p_ff[7]) - qte_pkg::OPW'(d_p_ff[6])) <<< 1;
         e_ax_ff <= qte_pkg::OPW'(d_p_ff[0]) + qte_pkg::OPW'(d_p_ff[2])
                  - qte_pkg::OPW'(d_p_ff[1]) - qte_pkg::OPW'(d_p_ff[3]);
         e_lo_ff <= qte_pkg::OPW'(d_p_ff[10]) + qte_pkg::OPW'(d_p_ff[11]);
         e_hi_ff <= qte_pkg::OPW'(d_p_ff[12]) + qte_pkg::OPW'(d_p_ff[13]);

         f_zero_ff <= e_zero_ff;
         f_as_ff   <= qte_pkg::LW'(s_abs[qte_pkg::OPW-2:0]) << qte_pkg::LIMIT_SHIFT;
         f_ln_ff   <= qte_pkg::LW'(gimbal_limit) * qte_pkg::LW'(e_n_ff[qte_pkg::OPW-2:0]);
         f_lohi_ff <= qte_pkg::RW'(e_lo_ff[qte_pkg::SQRT_STEPS-1:0])
                    * qte_pkg::RW'(e_hi_ff[qte_pkg::SQRT_STEPS-1:0]);
         f_s_ff  <= e_s_ff;
         f_ry_ff <= e_ry_ff;
         f_rx_ff <= e_rx_ff;
         f_yy_ff <= e_yy_ff;
         f_yx_ff <= e_yx_ff;
         f_ay_ff <= e_ay_ff;
         f_ax_ff <= e_ax_ff;

         g_ff <= g_in;
      end
   end

   always_comb begin
      logic lk;
      lk = !f_zero_ff && (f_as_ff >= f_ln_ff);
      g_in.valid       = vf_ff;
      g_in.rem         = f_lohi_ff;
      g_in.root        = '0;
      g_in.side.s      = f_s_ff;
      g_in.side.roll_y = lk ? f_ay_ff : f_ry_ff;
      g_in.side.roll_x = lk ? f_ax_ff : f_rx_ff;
      g_in.side.yaw_y  = f_yy_ff;
      g_in.side.yaw_x  = f_yx_ff;
      g_in.side.locked = lk;
      g_in.side.zeroq  = f_zero_ff;
   end

   always_comb begin
      out       = g_ff;
      out.valid = vg_ff;
   end

endmodule

// ----- hw/rtl/qte_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per transfer.
// Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_sqrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [qte_pkg::STEP_W-1:0]  step,
   input  qte_pkg::qte_root_type       in_data,
   output qte_pkg::qte_root_type       out_data
);

   qte_pkg::qte_root_type nxt_in, nxt_ff;
   logic                  valid_ff;

   always_comb begin
      logic [qte_pkg::RW:0] t;
      t = (qte_pkg::RW'(in_data.root) << (step + 1'b1))
        + ((qte_pkg::RW+1)'(1) << {step, 1'b0});
      nxt_in = in_data;
      if ((qte_pkg::RW+1)'(in_data.rem) >= t) begin
         nxt_in.rem  = in_data.rem - qte_pkg::RW'(t);
         nxt_in.root = in_data.root | (qte_pkg::SQRT_STEPS'(1) << step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_data.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff <= nxt_in;
      end
   end

   always_comb begin
      out_data       = nxt_ff;
      out_data.valid = valid_ff;
   end

endmodule

// ----- hw/rtl/qte_cordic_cell.sv -----
// One CORDIC vectoring step for the roll, pitch and yaw lanes side by side.
// Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_cordic_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [qte_pkg::STEP_W-1:0]  step,
   input  logic [31:0]                 atan_step,
   input  qte_pkg::qte_cord_type       in_data,
   output qte_pkg::qte_cord_type       out_data
);

   qte_pkg::qte_cord_type nxt_in, nxt_ff;
   logic                  valid_ff;

   always_comb begin
      logic signed [qte_pkg::VW-1:0] xv, yv;
      logic signed [qte_pkg::ZW-1:0] zv, av;
      nxt_in = in_data;
      av = $signed(qte_pkg::ZW'(atan_step));
      for (int l = 0; l < 3; l++) begin
         xv = in_data.lane[l].x;
         yv = in_data.lane[l].y;
         zv = in_data.lane[l].z;
         if (yv >= 0) begin
            nxt_in.lane[l].x = xv + (yv >>> step);
            nxt_in.lane[l].y = yv - (xv >>> step);
            nxt_in.lane[l].z = zv + av;
         end else begin
            nxt_in.lane[l].x = xv - (yv >>> step);
            nxt_in.lane[l].y = yv + (xv >>> step);
            nxt_in.lane[l].z = zv - av;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_data.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxt_ff <= nxt_in;
      end
   end

   always_comb begin
      out_data       = nxt_ff;
      out_data.valid = valid_ff;
   end

endmodule
